FILE: rtl/core/polygon_edge_walker_defines.svh
// ----------------------------------------------------------------------------
// Polygon edge walker assertion macros
// Shared concurrent assertion forms for the edge walker RTL.
// ----------------------------------------------------------------------------
`ifndef POLYGON_EDGE_WALKER_DEFINES_SVH
`define POLYGON_EDGE_WALKER_DEFINES_SVH

`ifndef ASSERT_OFF
`define PEW_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");
`define PEW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");
`else
`define PEW_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define PEW_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/core/pew_pkg.sv
// ----------------------------------------------------------------------------
// Polygon edge walker package
// Shared constants, controller states and control/status structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pew_pkg;

   localparam int COORD_BITS_DEF = 16;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_STEP = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SETUP,
      ST_SKIP
   } state_type;

   typedef struct packed {
      logic load;
      logic div_start;
      logic setup;
      logic advance;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      logic h_pos;
      logic skip;
      logic lines_nz;
      logic rsp_busy;
   } dp_sts_type;

endpackage

FILE: rtl/core/pew_div.sv
// ----------------------------------------------------------------------------
// Edge walker divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pew_div #(
   parameter int COORD_BITS = pew_pkg::COORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [COORD_BITS-1:0] dividend,
   input  logic [COORD_BITS-1:0] divisor,
   output logic                  busy,
   output logic                  done,
   output logic [COORD_BITS-1:0] quotient,
   output logic [COORD_BITS-1:0] remainder
);

   localparam int CW = (COORD_BITS > 1) ? $clog2(COORD_BITS) : 1;

   logic              busy_ff, busy_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [COORD_BITS-1:0] rem_ff, rem_in;
   logic [COORD_BITS-1:0] quo_ff, quo_in;
   logic [COORD_BITS-1:0] dvs_ff, dvs_in;
   logic [COORD_BITS:0]   shifted;
   logic [COORD_BITS:0]   diff;
   logic                  fits;

   assign shifted = {rem_ff, quo_ff[COORD_BITS-1]};
   assign diff    = shifted - {1'b0, dvs_ff};
   assign fits    = (shifted >= {1'b0, dvs_ff});
   assign done    = busy_ff && (count_ff == CW'(COORD_BITS - 1));

   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         quo_in   = dividend;
         dvs_in   = divisor;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[COORD_BITS-1:0] : shifted[COORD_BITS-1:0];
         quo_in   = {quo_ff[COORD_BITS-2:0], fits};
         count_in = count_ff + CW'(1);
         if (done) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

FILE: rtl/core/pew_ctrl.sv
// ----------------------------------------------------------------------------
// Edge walker controller
// Sequences edge load, division, set-up, skip and scan-line steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pew_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_command,
   output logic                   req_tready,
   input  pew_pkg::dp_sts_type    sts,
   input  logic                   div_done,
   output pew_pkg::dp_cmd_type    cmd
);

   pew_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pew_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         pew_pkg::ST_IDLE: begin
            req_tready = !sts.rsp_busy;
            if (req_tvalid && !sts.rsp_busy) begin
               if (req_command == pew_pkg::CMD_LOAD) begin
                  cmd.load = 1'b1;
                  if (sts.h_pos) begin
                     cmd.div_start = 1'b1;
                     state_in      = pew_pkg::ST_DIVIDE;
                  end
               end else if (sts.lines_nz) begin
                  cmd.emit    = 1'b1;
                  cmd.advance = 1'b1;
               end
            end
         end
         pew_pkg::ST_DIVIDE: begin
            if (div_done) begin
               state_in = pew_pkg::ST_SETUP;
            end
         end
         pew_pkg::ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = sts.skip ? pew_pkg::ST_SKIP : pew_pkg::ST_IDLE;
         end
         pew_pkg::ST_SKIP: begin
            cmd.advance = 1'b1;
            state_in    = pew_pkg::ST_IDLE;
         end
         default: begin
            state_in = pew_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/core/pew_dpath.sv
// ----------------------------------------------------------------------------
// Edge walker datapath
// Edge registers, error-term stepping and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pew_dpath #(
   parameter int COORD_BITS = pew_pkg::COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  pew_pkg::dp_cmd_type          cmd,
   output pew_pkg::dp_sts_type          sts,
   input  logic [COORD_BITS-1:0]        x_start,
   input  logic [COORD_BITS-1:0]        y_start,
   input  logic [COORD_BITS-1:0]        x_end,
   input  logic [COORD_BITS-1:0]        y_end,
   input  logic                         right_side,
   input  logic                         skip_first,
   output logic [COORD_BITS-1:0]        div_dividend,
   output logic [COORD_BITS-1:0]        div_divisor,
   input  logic [COORD_BITS-1:0]        quotient,
   input  logic [COORD_BITS-1:0]        remainder,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output logic signed [COORD_BITS:0]   rsp_boundary_x,
   output logic [COORD_BITS-1:0]        rsp_line_offset,
   output logic                         rsp_is_right,
   output logic                         rsp_last
);

   localparam int CB = COORD_BITS;
   localparam int XW = COORD_BITS + 2;

   logic [CB:0]   dx, dy, dx_mag;
   logic          h_pos;

   logic [XW-1:0] cur_x_ff, cur_x_in;
   logic [XW-1:0] err_ff, err_in;
   logic [XW-1:0] whole_ff, whole_in;
   logic [CB-1:0] height_ff, height_in;
   logic [CB-1:0] estep_ff, estep_in;
   logic          dir_ff, dir_in;
   logic          falling_ff, falling_in;
   logic          side_ff, side_in;
   logic          skip_ff, skip_in;
   logic [CB:0]   lines_ff, lines_in;
   logic [CB-1:0] count_ff, count_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [CB:0]   rsp_bx_ff, rsp_bx_in;
   logic [CB-1:0] rsp_off_ff, rsp_off_in;
   logic          rsp_right_ff, rsp_right_in;
   logic          rsp_last_ff, rsp_last_in;

   logic [XW-1:0] x_sum, e_sum, x_adj, adv_x, adv_e;
   logic          e_pos;

   assign dx     = {x_end[CB-1], x_end} - {x_start[CB-1], x_start};
   assign dy     = {y_end[CB-1], y_end} - {y_start[CB-1], y_start};
   assign dx_mag = dx[CB] ? (~dx + (CB+1)'(1)) : dx;
   assign h_pos  = !dy[CB] && (dy != '0);

   assign div_dividend = dx_mag[CB-1:0];
   assign div_divisor  = dy[CB-1:0];

   // error-term step
   assign x_sum = cur_x_ff + whole_ff;
   assign e_sum = err_ff + {2'b00, estep_ff};
   assign e_pos = !e_sum[XW-1] && (e_sum != '0);
   assign x_adj = dir_ff ? XW'(1) : {XW{1'b1}};
   assign adv_x = e_pos ? (x_sum + x_adj) : x_sum;
   assign adv_e = e_pos ? (e_sum - {2'b00, height_ff}) : e_sum;

   always_comb begin
      cur_x_in   = cur_x_ff;
      err_in     = err_ff;
      whole_in   = whole_ff;
      height_in  = height_ff;
      estep_in   = estep_ff;
      dir_in     = dir_ff;
      falling_in = falling_ff;
      side_in    = side_ff;
      skip_in    = skip_ff;
      lines_in   = lines_ff;
      count_in   = count_ff;
      priority if (cmd.load) begin
         cur_x_in   = {{2{x_start[CB-1]}}, x_start};
         err_in     = '0;
         whole_in   = '0;
         estep_in   = '0;
         height_in  = h_pos ? dy[CB-1:0] : '0;
         dir_in     = !dx[CB] && (dx != '0);
         falling_in = dx[CB];
         side_in    = right_side;
         skip_in    = skip_first;
         count_in   = '0;
         lines_in   = h_pos ? ({1'b0, dy[CB-1:0]} - (CB+1)'(skip_first)) : '0;
      end else if (cmd.setup) begin
         whole_in = dir_ff ? {2'b00, quotient} : (~{2'b00, quotient} + XW'(1));
         estep_in = remainder;
         err_in   = falling_ff ? (XW'(1) - {2'b00, height_ff}) : '0;
      end else if (cmd.advance) begin
         cur_x_in = adv_x;
         err_in   = adv_e;
         if (cmd.emit) begin
            lines_in = lines_ff - (CB+1)'(1);
            count_in = count_ff + CB'(1);
         end
      end
   end

   always_comb begin
      rsp_bx_in    = rsp_bx_ff;
      rsp_off_in   = rsp_off_ff;
      rsp_right_in = rsp_right_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_bx_in    = cur_x_ff[CB:0] + (CB+1)'(side_ff);
         rsp_off_in   = count_ff;
         rsp_right_in = side_ff;
         rsp_last_in  = (lines_ff == (CB+1)'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lines_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         lines_ff     <= lines_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff     <= cur_x_in;
      err_ff       <= err_in;
      whole_ff     <= whole_in;
      height_ff    <= height_in;
      estep_ff     <= estep_in;
      dir_ff       <= dir_in;
      falling_ff   <= falling_in;
      side_ff      <= side_in;
      skip_ff      <= skip_in;
      count_ff     <= count_in;
      rsp_bx_ff    <= rsp_bx_in;
      rsp_off_ff   <= rsp_off_in;
      rsp_right_ff <= rsp_right_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign sts.h_pos    = h_pos;
   assign sts.skip     = skip_ff;
   assign sts.lines_nz = (lines_ff != '0);
   assign sts.rsp_busy = rsp_valid_ff && !rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_boundary_x  = signed'(rsp_bx_ff);
   assign rsp_line_offset = rsp_off_ff;
   assign rsp_is_right    = rsp_right_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

FILE: rtl/core/polygon_edge_walker.sv
// ----------------------------------------------------------------------------
// Polygon edge walker
// Scan-converts one polygon edge into one boundary x per scan line. A step
// beat with an active edge returns one result beat from the following cycle
// on, and steps are taken one per cycle while results keep draining. A load
// beat with positive height holds the input after acceptance through the
// divide, set-up and (with skip-first) skip states: the restoring divider
// that forms the whole-pixel step and remainder yields one quotient bit per
// cycle. A load with zero or negative height completes in its acceptance
// cycle, and steps that find no active edge are consumed without a result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "polygon_edge_walker_defines.svh"

module polygon_edge_walker #(
   parameter int COORD_BITS = pew_pkg::COORD_BITS_DEF
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_tvalid,
   output logic                                        req_tready,
   // x_start, y_start, x_end, y_end, right_side, skip_first, zero fill
   input  logic [((4*COORD_BITS+2+7)/8)*8-1:0]         req_tdata,
   // command
   input  logic                                        req_tuser,
   output logic                                        rsp_tvalid,
   input  logic                                        rsp_tready,
   // boundary_x, line_offset, zero fill
   output logic [((2*COORD_BITS+1+7)/8)*8-1:0]         rsp_tdata,
   // is_right
   output logic                                        rsp_tuser,
   output logic                                        rsp_tlast
);

   localparam int CB         = COORD_BITS;
   localparam int RSP_DATA_W = ((2*COORD_BITS+1+7)/8)*8;

   pew_pkg::dp_cmd_type cmd;
   pew_pkg::dp_sts_type sts;

   logic                 div_start_w;
   logic                 div_busy;
   logic                 div_done;
   logic [CB-1:0]        div_dividend;
   logic [CB-1:0]        div_divisor;
   logic [CB-1:0]        quotient;
   logic [CB-1:0]        remainder;
   logic signed [CB:0]   boundary_x;
   logic [CB-1:0]        line_offset;
   logic                 step_beat;
   logic                 load_beat;

   assign div_start_w = cmd.div_start;

   pew_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_command (req_tuser),
      .req_tready  (req_tready),
      .sts         (sts),
      .div_done    (div_done),
      .cmd         (cmd)
   );

   pew_div #(
      .COORD_BITS (COORD_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start_w),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .busy      (div_busy),
      .done      (div_done),
      .quotient  (quotient),
      .remainder (remainder)
   );

   pew_dpath #(
      .COORD_BITS (COORD_BITS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .x_start         (req_tdata[CB-1:0]),
      .y_start         (req_tdata[2*CB-1:CB]),
      .x_end           (req_tdata[3*CB-1:2*CB]),
      .y_end           (req_tdata[4*CB-1:3*CB]),
      .right_side      (req_tdata[4*CB]),
      .skip_first      (req_tdata[4*CB+1]),
      .div_dividend    (div_dividend),
      .div_divisor     (div_divisor),
      .quotient        (quotient),
      .remainder       (remainder),
      .rsp_ready       (rsp_tready),
      .rsp_valid       (rsp_tvalid),
      .rsp_boundary_x  (boundary_x),
      .rsp_line_offset (line_offset),
      .rsp_is_right    (rsp_tuser),
      .rsp_last        (rsp_tlast)
   );

   assign rsp_tdata = RSP_DATA_W'({line_offset, boundary_x});

   assign step_beat = req_tvalid && req_tready && (req_tuser == pew_pkg::CMD_STEP)
                      && sts.lines_nz;
   assign load_beat = req_tvalid && req_tready && (req_tuser == pew_pkg::CMD_LOAD)
                      && sts.h_pos;

   `PEW_ASSERT_IMPLY(a_no_accept_while_dividing, clock, reset, div_busy, !req_tready)
   `PEW_ASSERT_NEXT(a_step_gives_beat, clock, reset, step_beat, rsp_tvalid)
   `PEW_ASSERT_NEXT(a_load_holds_input, clock, reset, load_beat, !req_tready && div_busy)

endmodule
